[rtl/core/segment_fit_allocator_defines.svh]
// ----------------------------------------------------------------------------
// segment fit allocator assertion macros
// shared checking helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SEGMENT_FIT_ALLOCATOR_DEFINES_SVH
`define SEGMENT_FIT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on the block clock
`define SFA_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("segment_fit_allocator check failed");
// next-cycle implication on the block clock
`define SFA_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("segment_fit_allocator check failed");
`else
`define SFA_ASSERT_IMP(lbl, a, b)
`define SFA_ASSERT_NXT(lbl, a, b)
`endif
`endif

[rtl/core/sfa_pkg.sv]
// ----------------------------------------------------------------------------
// sfa_pkg
// shared types and codes of the segment fit allocator
// ----------------------------------------------------------------------------
package sfa_pkg;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_BEST  = 2'd1,
        OP_WORST = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NOOWNER = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_POOL_LIMIT = 2'd1;

    localparam int POOL_BASE_RST  = 1;
    localparam int POOL_LIMIT_RST = 512;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_SCAN,
        S_A_SPOS,
        S_F_OWN,
        S_F_HPOS,
        S_F_SREM,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_HSCAN,
        CMD_CARVE,
        CMD_SPOS,
        CMD_SINSERT,
        CMD_OSCAN,
        CMD_FLATCH,
        CMD_HPOS,
        CMD_MERGE,
        CMD_SREMOVE
    } cmd_t;

    typedef struct packed {
        logic size_zero;
        logic hscan_done;
        logic pick_found;
        logic seg_full;
        logic spos_done;
        logic own_done;
        logic own_match;
        logic hpos_done;
        logic merge_blocked;
    } dp_status_t;

endpackage

[rtl/core/sfa_ctrl.sv]
// ----------------------------------------------------------------------------
// sfa_ctrl
// request sequencer: steps the datapath through scan, carve and merge phases
// ----------------------------------------------------------------------------
module sfa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  sfa_pkg::op_t        s_op,
    input  sfa_pkg::dp_status_t dp_sts,
    input  logic                out_free,
    output logic                s_ready,
    output sfa_pkg::cmd_t       cmd,
    output logic                resp_load,
    output sfa_pkg::status_t    resp_status
);
    import sfa_pkg::*;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        resp_load  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = (s_op == OP_FREE) ? S_F_OWN : S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                priority if (dp_sts.size_zero) begin
                    st_next    = ST_NOFIT;
                    state_next = S_RESP;
                end else if (dp_sts.hscan_done) begin
                    priority if (!dp_sts.pick_found) begin
                        st_next    = ST_NOFIT;
                        state_next = S_RESP;
                    end else if (dp_sts.seg_full) begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        cmd        = CMD_CARVE;
                        state_next = S_A_SPOS;
                    end
                end else begin
                    cmd = CMD_HSCAN;
                end
            end
            S_A_SPOS: begin
                if (dp_sts.spos_done) begin
                    cmd        = CMD_SINSERT;
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end else begin
                    cmd = CMD_SPOS;
                end
            end
            S_F_OWN: begin
                if (dp_sts.own_done) begin
                    if (dp_sts.own_match) begin
                        cmd        = CMD_FLATCH;
                        state_next = S_F_HPOS;
                    end else begin
                        st_next    = ST_NOOWNER;
                        state_next = S_RESP;
                    end
                end else begin
                    cmd = CMD_OSCAN;
                end
            end
            S_F_HPOS: begin
                if (dp_sts.hpos_done) begin
                    if (dp_sts.merge_blocked) begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        cmd        = CMD_MERGE;
                        state_next = S_F_SREM;
                    end
                end else begin
                    cmd = CMD_HPOS;
                end
            end
            S_F_SREM: begin
                cmd        = CMD_SREMOVE;
                st_next    = ST_OK;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    resp_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign resp_status = st_reg;

endmodule

[rtl/core/sfa_datapath.sv]
// ----------------------------------------------------------------------------
// sfa_datapath
// hole and segment tables, scan index and per-request working registers
// ----------------------------------------------------------------------------
module sfa_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sfa_pkg::cmd_t          cmd,
    input  logic [1:0]             in_op,
    input  logic [15:0]            in_size,
    input  logic [15:0]            in_owner,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [15:0]            cfg_data,
    output sfa_pkg::dp_status_t    dp_sts,
    output logic [ADDR_BITS-1:0]   res_lo,
    output logic [ADDR_BITS-1:0]   res_hi
);
    import sfa_pkg::*;

    localparam int N  = TABLE_ENTRIES;
    localparam int AW = ADDR_BITS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [AW-1:0] BASE_RST  = AW'(POOL_BASE_RST);
    localparam logic [AW-1:0] LIMIT_RST = AW'(POOL_LIMIT_RST);

    logic [AW-1:0] base_reg, base_next, limit_reg, limit_next;
    logic [AW-1:0] hs_reg [N];
    logic [AW-1:0] hs_next [N];
    logic [AW-1:0] he_reg [N];
    logic [AW-1:0] he_next [N];
    logic [AW-1:0] sl_reg [N];
    logic [AW-1:0] sl_next [N];
    logic [AW-1:0] sh_reg [N];
    logic [AW-1:0] sh_next [N];
    logic [15:0]   so_reg [N];
    logic [15:0]   so_next [N];
    logic [CW-1:0] nh_reg, nh_next, ns_reg, ns_next, idx_reg, idx_next;
    op_t           op_reg, op_next;
    logic [AW-1:0] size_reg, size_next;
    logic [15:0]   owner_reg, owner_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pick_reg, pick_next, sidx_reg, sidx_next;
    logic [AW-1:0] pick_w_reg, pick_w_next;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next, prev_reg, prev_next;

    logic [IW-1:0] ri;
    logic          in_h, in_s, fits, better, with_prev, with_next;
    logic [AW-1:0] cur_hs, cur_he, w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RST;
            limit_reg <= LIMIT_RST;
            hs_reg[0] <= BASE_RST;
            he_reg[0] <= LIMIT_RST;
            nh_reg    <= (LIMIT_RST > BASE_RST) ? CW'(1) : '0;
            ns_reg    <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            base_reg  <= base_next;
            limit_reg <= limit_next;
            hs_reg    <= hs_next;
            he_reg    <= he_next;
            nh_reg    <= nh_next;
            ns_reg    <= ns_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        sl_reg     <= sl_next;
        sh_reg     <= sh_next;
        so_reg     <= so_next;
        op_reg     <= op_next;
        size_reg   <= size_next;
        owner_reg  <= owner_next;
        pick_reg   <= pick_next;
        pick_w_reg <= pick_w_next;
        sidx_reg   <= sidx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        prev_reg   <= prev_next;
    end

    // status seen by the sequencer
    always_comb begin
        ri     = idx_reg[IW-1:0];
        in_h   = idx_reg < nh_reg;
        in_s   = idx_reg < ns_reg;
        cur_hs = hs_reg[ri];
        cur_he = he_reg[ri];
        w      = cur_he - cur_hs;
        fits   = in_h && (w >= size_reg);
        better = !found_reg || (op_reg == OP_BEST && w < pick_w_reg)
                 || (op_reg == OP_WORST && w > pick_w_reg);
        with_prev = (idx_reg != '0) && (prev_reg == lo_reg);
        with_next = in_h && (cur_hs == hi_reg);

        dp_sts.size_zero     = (size_reg == '0);
        dp_sts.pick_found    = found_reg;
        dp_sts.hscan_done    = !in_h || (op_reg == OP_FIRST && found_reg);
        dp_sts.seg_full      = (ns_reg == CW'(N));
        dp_sts.spos_done     = !(in_s && sl_reg[ri] < lo_reg);
        dp_sts.own_match     = in_s && (so_reg[ri] == owner_reg);
        dp_sts.own_done      = !in_s || dp_sts.own_match;
        dp_sts.hpos_done     = !(in_h && cur_hs < lo_reg);
        dp_sts.merge_blocked = !with_prev && !with_next && (nh_reg == CW'(N));
    end

    always_comb begin
        base_next   = base_reg;
        limit_next  = limit_reg;
        hs_next     = hs_reg;
        he_next     = he_reg;
        sl_next     = sl_reg;
        sh_next     = sh_reg;
        so_next     = so_reg;
        nh_next     = nh_reg;
        ns_next     = ns_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        size_next   = size_reg;
        owner_next  = owner_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        pick_w_next = pick_w_reg;
        sidx_next   = sidx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        prev_next   = prev_reg;

        if (cfg_we) begin
            if (cfg_idx == REG_POOL_BASE) begin
                base_next = AW'(cfg_data);
            end else if (cfg_idx == REG_POOL_LIMIT) begin
                // pool re-init: one hole (none when limit <= base), no segments
                limit_next = AW'(cfg_data);
                hs_next[0] = base_reg;
                he_next[0] = AW'(cfg_data);
                nh_next    = (AW'(cfg_data) > base_reg) ? CW'(1) : '0;
                ns_next    = '0;
            end
        end else begin
            unique case (cmd)
                CMD_LOAD: begin
                    op_next    = op_t'(in_op);
                    size_next  = AW'(in_size);
                    owner_next = in_owner;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
                CMD_HSCAN: begin
                    if (in_h) begin
                        if (fits && better) begin
                            found_next  = 1'b1;
                            pick_next   = ri;
                            pick_w_next = w;
                            lo_next     = cur_hs;
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                end
                CMD_CARVE: begin
                    hi_next  = lo_reg + size_reg;
                    idx_next = '0;
                    if (pick_w_reg == size_reg) begin
                        // exact fit drops the hole
                        for (int i = 0; i < N; i++) begin
                            if (IW'(i) >= pick_reg && CW'(i + 1) < nh_reg) begin
                                hs_next[i] = hs_reg[(i + 1 < N) ? i + 1 : i];
                                he_next[i] = he_reg[(i + 1 < N) ? i + 1 : i];
                            end
                        end
                        nh_next = nh_reg - CW'(1);
                    end else begin
                        hs_next[pick_reg] = lo_reg + size_reg;
                    end
                end
                CMD_SPOS: begin
                    if (!dp_sts.spos_done) begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                CMD_SINSERT: begin
                    for (int i = 0; i < N; i++) begin
                        if (CW'(i) > idx_reg && CW'(i) <= ns_reg) begin
                            sl_next[i] = sl_reg[(i > 0) ? i - 1 : i];
                            sh_next[i] = sh_reg[(i > 0) ? i - 1 : i];
                            so_next[i] = so_reg[(i > 0) ? i - 1 : i];
                        end else if (CW'(i) == idx_reg) begin
                            sl_next[i] = lo_reg;
                            sh_next[i] = hi_reg;
                            so_next[i] = owner_reg;
                        end
                    end
                    ns_next = ns_reg + CW'(1);
                end
                CMD_OSCAN: begin
                    if (!dp_sts.own_done) begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                CMD_FLATCH: begin
                    sidx_next = ri;
                    lo_next   = sl_reg[ri];
                    hi_next   = sh_reg[ri];
                    idx_next  = '0;
                end
                CMD_HPOS: begin
                    if (!dp_sts.hpos_done) begin
                        prev_next = cur_he;
                        idx_next  = idx_reg + CW'(1);
                    end
                end
                CMD_MERGE: begin
                    for (int i = 0; i < N; i++) begin
                        priority if (with_prev && with_next) begin
                            if (CW'(i + 1) == idx_reg) begin
                                he_next[i] = cur_he;
                            end else if (CW'(i) >= idx_reg && CW'(i + 1) < nh_reg) begin
                                hs_next[i] = hs_reg[(i + 1 < N) ? i + 1 : i];
                                he_next[i] = he_reg[(i + 1 < N) ? i + 1 : i];
                            end
                        end else if (with_prev) begin
                            if (CW'(i + 1) == idx_reg) begin
                                he_next[i] = hi_reg;
                            end
                        end else if (with_next) begin
                            if (CW'(i) == idx_reg) begin
                                hs_next[i] = lo_reg;
                            end
                        end else begin
                            if (CW'(i) > idx_reg && CW'(i) <= nh_reg) begin
                                hs_next[i] = hs_reg[(i > 0) ? i - 1 : i];
                                he_next[i] = he_reg[(i > 0) ? i - 1 : i];
                            end else if (CW'(i) == idx_reg) begin
                                hs_next[i] = lo_reg;
                                he_next[i] = hi_reg;
                            end
                        end
                    end
                    priority if (with_prev && with_next) begin
                        nh_next = nh_reg - CW'(1);
                    end else if (!with_prev && !with_next) begin
                        nh_next = nh_reg + CW'(1);
                    end else begin
                        nh_next = nh_reg;
                    end
                end
                CMD_SREMOVE: begin
                    for (int i = 0; i < N; i++) begin
                        if (IW'(i) >= sidx_reg && CW'(i + 1) < ns_reg) begin
                            sl_next[i] = sl_reg[(i + 1 < N) ? i + 1 : i];
                            sh_next[i] = sh_reg[(i + 1 < N) ? i + 1 : i];
                            so_next[i] = so_reg[(i + 1 < N) ? i + 1 : i];
                        end
                    end
                    ns_next = ns_reg - CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign res_lo = lo_reg;
    assign res_hi = hi_reg;

endmodule

[rtl/core/segment_fit_allocator.sv]
// ----------------------------------------------------------------------------
// segment_fit_allocator
// first, best and worst fit allocator over one contiguous address pool
// ----------------------------------------------------------------------------
// usage:
// - request channel s_*: op (first/best/worst fit allocate, or free), size and
//   owner id; one transaction per request, taken only while the sequencer idles
// - result channel m_*: one transaction per request with status and the
//   segment bounds; bounds read zero on any error status
// - config channel cfg_*: index 0 pool_base, index 1 pool_limit; writing the
//   limit rebuilds the pool as one hole and drops all segments; always ready
// table walk: a request walks the hole table and the segment table one entry
//   per cycle
// throughput: one request in flight; the result sits in an output register,
//   so the next request is taken while the receiver stalls, and only its
//   result waits until the held one is taken
// reset: pool [1, 512) as a single hole, no segments, no result pending
// ----------------------------------------------------------------------------
module segment_fit_allocator #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_request_size,
    input  logic [15:0] s_owner_id,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_seg_start,
    output logic [15:0] m_seg_end,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import sfa_pkg::*;

`include "segment_fit_allocator_defines.svh"

    cmd_t                 cmd;
    dp_status_t           dp_sts;
    status_t              resp_status;
    logic                 resp_load;
    logic                 out_free;
    logic [ADDR_BITS-1:0] res_lo, res_hi;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [15:0] m_start_reg, m_start_next, m_end_reg, m_end_next;

    // output slot is free when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    sfa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_op        (op_t'(s_op)),
        .dp_sts      (dp_sts),
        .out_free    (out_free),
        .s_ready     (s_ready),
        .cmd         (cmd),
        .resp_load   (resp_load),
        .resp_status (resp_status)
    );

    sfa_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_op    (s_op),
        .in_size  (s_request_size),
        .in_owner (s_owner_id),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_wdata),
        .dp_sts   (dp_sts),
        .res_lo   (res_lo),
        .res_hi   (res_hi)
    );

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_start_next  = m_start_reg;
        m_end_next    = m_end_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (resp_load) begin
            m_valid_next  = 1'b1;
            m_status_next = resp_status;
            // error transactions carry zero bounds
            m_start_next  = (resp_status == ST_OK) ? 16'(res_lo) : '0;
            m_end_next    = (resp_status == ST_OK) ? 16'(res_hi) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_start_reg  <= m_start_next;
        m_end_reg    <= m_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_seg_start = m_start_reg;
    assign m_seg_end   = m_end_reg;

    // a held result is never overwritten
    `SFA_ASSERT_IMP(a_no_overwrite, resp_load, out_free)
    // an accepted request leaves the sequencer busy
    `SFA_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // error results report zero bounds
    `SFA_ASSERT_IMP(a_err_zero, m_valid && m_status != ST_OK, m_seg_start == '0 && m_seg_end == '0)

endmodule
